[src/efpd_pkg.sv]
// ----------------------------------------------------------------------------
// efpd_pkg
// Shared widths, register codes, reset values and the result type of the
// escape framed packet deframer.
// ----------------------------------------------------------------------------
package efpd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd2;

    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd27;
    localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd3;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_IRQ    = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  packet_length;
        logic              last;
        logic              byte_valid;
    } result_t;

endpackage

[src/efpd_ifs.sv]
// ----------------------------------------------------------------------------
// efpd stream interfaces
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface efpd_rx_if;
    logic                       valid;
    logic                       ready;
    logic [efpd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efpd_res_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [efpd_pkg::BYTE_W-1:0] data_byte;
    logic [efpd_pkg::LEN_W-1:0]  packet_length;
    logic                       last;
    logic                       byte_valid;

    modport source (output valid, output kind, output data_byte, output packet_length,
                    output last, output byte_valid, input ready);
    modport sink   (input valid, input kind, input data_byte, input packet_length,
                    input last, input byte_valid, output ready);
endinterface

[src/efpd_store.sv]
// ----------------------------------------------------------------------------
// efpd_store
// Packet byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module efpd_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [efpd_pkg::BYTE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [efpd_pkg::BYTE_W-1:0] rdata
);

    logic [efpd_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [efpd_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/escape_framed_packet_deframer_core.sv]
// ----------------------------------------------------------------------------
// escape_framed_packet_deframer_core
// Escape byte-stuffing deframer with a packet store and a result queue.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the deframer is idle and its
// two-entry result queue has a free slot. Plain bytes and literal escapes of an
// open frame go into a STORE_DEPTH byte memory; bytes past the depth are
// dropped. An escape followed by a code that is not start, end or escape gives
// one interrupt item at once. Closing or reopening a frame gives the stored
// packet as a run of items with its length and a last mark (an empty packet
// gives a single item with byte_valid low). While a packet is read out the
// input is held off; each stored byte is read from the store in S_RD, then in
// S_WR the registered read data goes into the result queue once it has room.
// The store needs no clearing after reset. The user must write code registers
// through the cfg port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module escape_framed_packet_deframer_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [efpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [efpd_pkg::BYTE_W-1:0]    cfg_data,
    efpd_rx_if.sink                        rx,
    efpd_res_if.source                     res
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_WR   = 3'b100
    } state_t;

    // configuration
    logic [efpd_pkg::BYTE_W-1:0] escape_code_reg;
    logic [efpd_pkg::BYTE_W-1:0] start_code_reg;
    logic [efpd_pkg::BYTE_W-1:0] end_code_reg;

    // deframer state
    state_t            state_reg, state_next;
    logic              esc_pend_reg, esc_pend_next;
    logic              in_frame_reg, in_frame_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [FW-1:0]     len_reg, len_next;
    logic [AW-1:0]     idx_reg, idx_next;

    // result queue
    efpd_pkg::result_t slot_reg [2];
    logic              wp_reg, wp_next;
    logic              rp_reg, rp_next;
    logic [1:0]        cnt_reg, cnt_next;

    logic                        room;
    logic                        accept;
    logic                        push;
    logic                        pop;
    efpd_pkg::result_t           push_data;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [efpd_pkg::BYTE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [efpd_pkg::BYTE_W-1:0] mem_rdata;
    logic [efpd_pkg::BYTE_W-1:0] b;
    logic                        store_req;
    logic [efpd_pkg::BYTE_W-1:0] store_val;
    logic                        deliver;
    logic                        run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg <= efpd_pkg::ESCAPE_CODE_RST;
            start_code_reg  <= efpd_pkg::START_CODE_RST;
            end_code_reg    <= efpd_pkg::END_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                efpd_pkg::REG_ESCAPE_CODE: escape_code_reg <= cfg_data;
                efpd_pkg::REG_START_CODE:  start_code_reg  <= cfg_data;
                efpd_pkg::REG_END_CODE:    end_code_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign room      = (cnt_reg != 2'd2);
    assign rx.ready  = (state_reg == S_IDLE) && room;
    assign accept    = rx.valid && rx.ready;
    assign pop       = res.valid && res.ready;
    assign b         = rx.rx_byte;
    assign run_last  = ((FW'(idx_reg) + FW'(1)) == len_reg);

    always_comb
    begin
        state_next    = state_reg;
        esc_pend_next = esc_pend_reg;
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        push          = 1'b0;
        push_data     = '0;
        store_req     = 1'b0;
        store_val     = b;
        deliver       = 1'b0;
        mem_re        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (esc_pend_reg)
                    begin
                        esc_pend_next = 1'b0;
                        if (b == start_code_reg)
                        begin
                            deliver       = in_frame_reg;
                            fill_next     = '0;
                            in_frame_next = 1'b1;
                        end
                        else if (b == end_code_reg)
                        begin
                            deliver       = in_frame_reg;
                            fill_next     = '0;
                            in_frame_next = 1'b0;
                        end
                        else if (b == escape_code_reg)
                        begin
                            store_req = 1'b1;
                            store_val = escape_code_reg;
                        end
                        else
                        begin
                            push                    = 1'b1;
                            push_data.kind          = efpd_pkg::KIND_IRQ;
                            push_data.data_byte     = b;
                            push_data.packet_length = '0;
                            push_data.last          = 1'b1;
                            push_data.byte_valid    = 1'b1;
                        end
                    end
                    else if (b == escape_code_reg)
                    begin
                        esc_pend_next = 1'b1;
                    end
                    else
                    begin
                        store_req = 1'b1;
                    end

                    if (store_req && in_frame_reg && (fill_reg < FW'(STORE_DEPTH)))
                    begin
                        fill_next = fill_reg + FW'(1);
                    end

                    if (deliver)
                    begin
                        if (fill_reg == '0)
                        begin
                            // empty packet: one marker item
                            push                    = 1'b1;
                            push_data.kind          = efpd_pkg::KIND_PACKET;
                            push_data.data_byte     = '0;
                            push_data.packet_length = '0;
                            push_data.last          = 1'b1;
                            push_data.byte_valid    = 1'b0;
                        end
                        else
                        begin
                            len_next   = fill_reg;
                            idx_next   = '0;
                            state_next = S_RD;
                        end
                    end
                end
            end

            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_WR;
            end

            S_WR:
            begin
                if (room)
                begin
                    push                    = 1'b1;
                    push_data.kind          = efpd_pkg::KIND_PACKET;
                    push_data.data_byte     = mem_rdata;
                    push_data.packet_length = efpd_pkg::LEN_W'(len_reg);
                    push_data.last          = run_last;
                    push_data.byte_valid    = 1'b1;
                    if (run_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // writes happen only while idle and reads only during readout, so the
    // two ports never touch the store in the same cycle
    assign mem_we    = (state_reg == S_IDLE) && accept && store_req && in_frame_reg
                       && (fill_reg < FW'(STORE_DEPTH));
    assign mem_waddr = fill_reg[AW-1:0];
    assign mem_wdata = store_val;

    efpd_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    // result queue pointers
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            esc_pend_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            wp_reg       <= 1'b0;
            rp_reg       <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            esc_pend_reg <= esc_pend_next;
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    assign res.valid         = (cnt_reg != 2'd0);
    assign res.kind          = slot_reg[rp_reg].kind;
    assign res.data_byte     = slot_reg[rp_reg].data_byte;
    assign res.packet_length = slot_reg[rp_reg].packet_length;
    assign res.last          = slot_reg[rp_reg].last;
    assign res.byte_valid    = slot_reg[rp_reg].byte_valid;

endmodule
